[hdl/assert_macros.svh]
// Assertion macros shared by the palette quantizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define PQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pq_pkg.sv]
// Types, constants and helpers for the palette quantizer.
// Used by pq_cell, pq_pack and palette_quantize_nibble_pack.
package pq_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int ENTRIES_PER_REG = 8;
   localparam int IDX_W = 4;
   localparam int DIST_W = 7;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 64;

   // largest distance is 49 + 49 + 9, so this start value always loses
   localparam logic [DIST_W-1:0] DIST_MAX = 7'h7f;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_LOWER = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_UPPER = 8'd1;

   // data handed from cell to cell along the chain
   typedef struct packed {
      logic              valid;
      logic [2:0]        red;
      logic [2:0]        green;
      logic [1:0]        blue;
      logic [DIST_W-1:0] score;
      logic [IDX_W-1:0]  idx;
   } stage_type;

   // squared difference of two 3-bit components
   function automatic logic [5:0] sq_diff3(input logic [2:0] a, input logic [2:0] b);
      logic [2:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {3'b000, d} * {3'b000, d};
   endfunction

endpackage

[hdl/pq_cell.sv]
// One cell of the nearest-colour chain: holds a palette entry, scores the
// passing pixel against it and forwards the running best. Uses pq_pkg.
module pq_cell import pq_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       entry_we,
   input  logic [7:0] entry_wdata,
   input  stage_type  chain_in,
   output stage_type  chain_out
);

   logic [7:0] entry_ff;
   logic [7:0] entry_in;
   stage_type  stage_ff;
   stage_type  stage_in;
   logic [DIST_W-1:0] entry_score;

   // palette entry, written from the configuration port
   assign entry_in = entry_we ? entry_wdata : entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // distance of the pixel to this entry (RGB332: red 7:5, green 4:2, blue 1:0)
   assign entry_score = DIST_W'(sq_diff3(chain_in.red, entry_ff[7:5]))
                      + DIST_W'(sq_diff3(chain_in.green, entry_ff[4:2]))
                      + DIST_W'(sq_diff3({1'b0, chain_in.blue}, {1'b0, entry_ff[1:0]}));

   // strictly smaller wins, so the lower index keeps ties
   always_comb begin
      stage_in = chain_in;
      if (entry_score < chain_in.score) begin
         stage_in.score = entry_score;
         stage_in.idx   = IDX_W'(CELL_INDEX);
      end
   end

   // chain stage; only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign chain_out = stage_ff;

endmodule

[hdl/pq_pack.sv]
// Pairs chain results into bytes, high nibble first, and drives the result
// channel through an output register and a one-entry skid. Uses pq_pkg.
module pq_pack import pq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  stage_type  chain_in,
   output logic       chain_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);

   logic             odd_ff, odd_in;
   logic [IDX_W-1:0] held_ff, held_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [7:0]       skid_data_ff, skid_data_in;
   logic             take, push, pop;
   logic [7:0]       byte_new;

   assign take     = advance && chain_in.valid;
   assign push     = take && odd_ff;
   assign pop      = out_valid_ff && rsp_tready;
   assign byte_new = {held_ff, chain_in.idx};

   // pairing phase and pending even-pixel index
   always_comb begin
      odd_in  = odd_ff;
      held_in = held_ff;
      if (take) begin
         odd_in = ~odd_ff;
         if (!odd_ff) begin
            held_in = chain_in.idx;
         end
      end
   end

   // output register with skid behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = byte_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = byte_new;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff        <= 1'b0;
         held_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         odd_ff        <= odd_in;
         held_ff       <= held_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign chain_ready = ~skid_valid_ff;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;

endmodule

[hdl/palette_quantize_nibble_pack.sv]
// Top level of the palette quantizer: 16-cell nearest-colour chain and the
// nibble packer. Uses pq_pkg, pq_cell, pq_pack and assert_macros.svh.
//
// Usage:
//   req_*  : one RGB888 pixel per request, red in tdata[7:0], green in
//            [15:8], blue in [23:16].
//   rsp_*  : one byte per pixel pair, even pixel index in [7:4], odd in [3:0].
//   csr_*  : palette writes, index 0 loads entries 0-7, index 1 entries 8-15,
//            entry 8k in the lowest byte; other indexes are ignored.
//            Always ready; write only while no pixels are in flight.
// Throughput: one pixel per cycle unless stalled, one byte every second pixel.
// Path: the byte for an odd pixel appears on rsp_tvalid once that pixel has
//   passed the 16 cells of the chain (one per palette entry, one register
//   each) and then the output register.
// Reset clears the palette to zero, the pairing phase (next pixel is even)
//   and all in-flight pixels.
// Stall: the output register is backed by a one-entry skid; the chain keeps
//   taking pixels until the skid fills, then req_tready drops and the whole
//   chain holds until rsp_tready lets the skid drain.
`include "assert_macros.svh"

module palette_quantize_nibble_pack import pq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // red [7:0], green [15:8], blue [23:16]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,
   // packed_byte [7:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   stage_type chain_head;
   stage_type chain [NUM_ENTRIES];
   logic      advance;
   logic      chain_ready;
   logic      csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign advance   = chain_ready;
   assign req_tready = advance;

   // reduce the pixel to 3/3/2 bits and seed the running best
   always_comb begin
      chain_head.valid = req_tvalid;
      chain_head.red   = req_tdata[7:5];
      chain_head.green = req_tdata[15:13];
      chain_head.blue  = req_tdata[23:22];
      chain_head.score = DIST_MAX;
      chain_head.idx   = '0;
   end

   // one cell per palette entry
   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
      localparam logic [CSR_INDEX_W-1:0] REG_SEL =
         (k < ENTRIES_PER_REG) ? REG_PALETTE_LOWER : REG_PALETTE_UPPER;
      localparam int BYTE_POS = k % ENTRIES_PER_REG;

      pq_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .entry_we    (csr_write && (csr_index == REG_SEL)),
         .entry_wdata (csr_data[8*BYTE_POS +: 8]),
         .chain_in    ((k == 0) ? chain_head : chain[(k == 0) ? 0 : k-1]),
         .chain_out   (chain[k])
      );
   end

   pq_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .chain_in    (chain[NUM_ENTRIES-1]),
      .chain_ready (chain_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // request side only blocks while a finished byte is waiting
   `PQ_ASSERT(a_stall_needs_output, clock, reset, !req_tready |-> rsp_tvalid, "input stalled with no output pending")
   // an accepted pixel enters the first cell
   `PQ_ASSERT(a_accept_enters_chain, clock, reset, (req_tvalid && req_tready) |=> chain[0].valid, "accepted pixel lost at chain entry")
   // a stalled chain holds its last stage
   `PQ_ASSERT(a_chain_holds, clock, reset, (!req_tready && !$past(reset)) |=> $stable(chain[NUM_ENTRIES-1]), "chain moved while stalled")

endmodule

[tb/sv/palette_quantize_nibble_pack_test.sv]
// Self-checking bench for palette_quantize_nibble_pack: pixel requests in,
// packed palette-index bytes out, palette loaded through the csr channel.
// Depends on pq_pkg and the palette_quantize_nibble_pack RTL only.
module palette_quantize_nibble_pack_test import pq_pkg::*;;

   // pixel as carried on req_tdata, red in the lowest byte
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // indexes the block must ignore
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP   = 8'hff;

   // chain depth plus output register, with margin
   localparam int SETTLE_CYCLES = 24;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // own copy of the block state
   logic [CSR_DATA_W-1:0]  pal_lower;
   logic [CSR_DATA_W-1:0]  pal_upper;
   logic [IDX_W-1:0]       pending_idx;
   logic                   odd_pixel;

   logic [7:0] expected_bytes[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left    = 0;
   int error_count   = 0;
   int pixels_sent   = 0;
   int bytes_checked = 0;
   int palette_loads = 0;

   palette_quantize_nibble_pack i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // index of the closest palette entry, lowest index on a tie
   function automatic logic [IDX_W-1:0] nearest_entry(input pixel_type px);
      logic [7:0]       e;
      logic [IDX_W-1:0] win;
      int               dr, dg, db, sq_sum, best, k;
      best = 1 << 30;
      win  = '0;
      for (k = 0; k < NUM_ENTRIES; k++) begin
         e = (k < ENTRIES_PER_REG) ? pal_lower[8*(k % ENTRIES_PER_REG) +: 8]
                                   : pal_upper[8*(k % ENTRIES_PER_REG) +: 8];
         dr = int'(px.red[7:5]) - int'(e[7:5]);
         dg = int'(px.green[7:5]) - int'(e[4:2]);
         db = int'(px.blue[7:6]) - int'(e[1:0]);
         sq_sum = dr*dr + dg*dg + db*db;
         if (sq_sum < best) begin
            best = sq_sum;
            win  = k[IDX_W-1:0];
         end
      end
      return win;
   endfunction

   // pixel lying in the colour cell of one palette entry, low bits random
   function automatic pixel_type pixel_near(input int k);
      logic [7:0] e;
      pixel_type  px;
      e = (k < ENTRIES_PER_REG) ? pal_lower[8*(k % ENTRIES_PER_REG) +: 8]
                                : pal_upper[8*(k % ENTRIES_PER_REG) +: 8];
      px.red   = {e[7:5], 5'($urandom)};
      px.green = {e[4:2], 5'($urandom)};
      px.blue  = {e[1:0], 6'($urandom)};
      return px;
   endfunction

   // one pixel request, then update the pairing state
   task automatic send_pixel(input pixel_type px);
      logic [IDX_W-1:0] idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      idx = nearest_entry(px);
      if (!odd_pixel) begin
         pending_idx = idx;
         odd_pixel   = 1'b1;
      end else begin
         expected_bytes.push_back({pending_idx, idx});
         odd_pixel = 1'b0;
      end
   endtask

   // let every byte come out and the chain empty
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_bytes.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one csr write; the block must be idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      palette_loads++;
      if (idx == REG_PALETTE_LOWER)
         pal_lower = val;
      else if (idx == REG_PALETTE_UPPER)
         pal_upper = val;
      @(posedge clock);
   endtask

   task automatic load_palette(input logic [63:0] lo, input logic [63:0] hi);
      write_reg(REG_PALETTE_LOWER, lo);
      write_reg(REG_PALETTE_UPPER, hi);
   endtask

   // response side: random ready, long hold-off on request, byte check
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected packed_byte 0x%02h", rsp_tdata);
               error_count++;
            end else begin
               logic [7:0] want;
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want) begin
                  $error("packed_byte: expected 0x%02h, got 0x%02h", want, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // reset palette is all zero, so every pixel maps to entry 0
   task automatic test_reset_palette;
      send_pixel(24'h000000);
      send_pixel(24'hffffff);
      send_pixel(24'h80c040);
      send_pixel(24'h3fe01f);
      drain();
   endtask

   // distinct entries below, duplicates above: exact matches and ties
   task automatic test_match_and_ties;
      // entries 0..7: 00 e0 1c 03 ff 92 49 b6; 8..15 repeat them in reverse order
      load_palette(64'hb6_49_92_ff_03_1c_e0_00, 64'h00_e0_1c_03_ff_92_49_b6);
      send_pixel(24'h000000);   // black, exact on entry 0
      send_pixel(24'h0000ff);   // pure red, entry 1
      send_pixel(24'h00ff00);   // pure green, entry 2
      send_pixel(24'hff0000);   // pure blue, entry 3
      send_pixel(24'hffffff);   // white, entry 4 beats its copy at 11
      send_pixel(24'h7f9fbf);   // grey-ish, duplicate of entry 5 loses
      send_pixel(24'h40a0a0);   // closest to entry 7, tie with its copy at 8 breaks low
      send_pixel(24'h202020);
      send_pixel(24'hc01f60);
      send_pixel(24'h1fe0ff);
      drain();
   endtask

   // extreme palettes and ignored register indexes
   task automatic test_extreme_palette;
      load_palette(64'hffff_ffff_ffff_ffff, 64'h0);
      write_reg(REG_SPARE, 64'h1234_5678_9abc_def0);
      write_reg(REG_TOP, 64'hffff_ffff_ffff_ffff);
      send_pixel(24'h000000);   // only upper half matches
      send_pixel(24'hffffff);
      send_pixel(24'h808080);
      send_pixel(24'h7f7f7f);
      send_pixel(24'h00ff00);
      drain();
      load_palette(64'h0, 64'hffff_ffff_ffff_ffff);
      send_pixel(24'hffffff);
      send_pixel(24'h000000);
      drain();
   endtask

   // random pixels, mostly in the cell of some entry, palette changed now and then
   task automatic test_random_pixels(input int count, input int snd, input int rcv);
      int n;
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (n = 0; n < count; n++) begin
         if (n % 110 == 0) begin
            drain();
            case ($urandom_range(3))
               0: load_palette({$urandom, $urandom}, {$urandom, $urandom});
               // few distinct colours: many ties between duplicates
               1: load_palette({8{8'($urandom)}}, {4{16'($urandom)}});
               2: load_palette({$urandom, $urandom} & {8{8'he3}}, {$urandom, $urandom});
               default: load_palette({$urandom, $urandom}, {8{8'($urandom)}});
            endcase
         end
         if ($urandom_range(99) < 60)
            send_pixel(pixel_near($urandom_range(NUM_ENTRIES - 1)));
         else
            send_pixel(pixel_type'(24'($urandom)));
      end
      drain();
   endtask

   // hold the response side for a long while so the input stalls
   task automatic test_backpressure;
      int n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_palette({$urandom, $urandom}, {$urandom, $urandom});
      stall_left = 300;
      for (n = 0; n < 60; n++)
         send_pixel(pixel_type'(24'($urandom)));
      drain();
   endtask

   initial begin
      pal_lower   = '0;
      pal_upper   = '0;
      pending_idx = '0;
      odd_pixel   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_palette();
      test_match_and_ties();
      test_extreme_palette();
      test_random_pixels(550, 11, 84);
      test_random_pixels(550, 84, 11);
      test_random_pixels(550, 0, 0);
      test_backpressure();

      $display("%0d pixels quantised into %0d checked bytes, %0d csr writes,",
               pixels_sent, bytes_checked, palette_loads);
      $display("with random idling on both sides and one long response hold-off");
      if (error_count == 0) begin
         $display("palette_quantize_nibble_pack_test: clean");
      end else begin
         $display("palette_quantize_nibble_pack_test: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("palette_quantize_nibble_pack_test: errors");
      $finish;
   end

endmodule
